>>> src/vdt_pkg.sv
package vdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int COORD_W     = 32;
	localparam int ENTRY_W     = 3 * COORD_W;
	localparam int TOL_W       = 31;
	localparam int OUT_IDX_W   = 8;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} vdt_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} vdt_cmd_t;

	typedef struct packed {
		logic more;
		logic rd_vld;
		logic hit;
		logic out_free;
	} vdt_sts_t;

endpackage

>>> src/vdt_ctrl.sv
module vdt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vdt_pkg::vdt_sts_t  sts,
	output vdt_pkg::vdt_cmd_t  cmd
);
	import vdt_pkg::*;

	vdt_state_t state_q;
	vdt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				// stop on the first hit, or once every entry has been compared
				if (sts.hit) begin
					state_d = ST_RESULT;
				end else if (!sts.more && !sts.rd_vld) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/vdt_dpath.sv
module vdt_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vdt_pkg::vdt_cmd_t                cmd,
	output vdt_pkg::vdt_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [vdt_pkg::TOL_W-1:0]        cfg_data,
	input  logic signed [vdt_pkg::COORD_W-1:0] x_coord,
	input  logic signed [vdt_pkg::COORD_W-1:0] y_coord,
	input  logic signed [vdt_pkg::COORD_W-1:0] z_coord,
	input  logic                             new_mesh,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [vdt_pkg::OUT_IDX_W-1:0]    vertex_index,
	output logic                             is_new,
	output logic                             table_full
);
	import vdt_pkg::*;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

	logic [TOL_W-1:0]        tol_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        rd_ptr_q;
	logic [IDX_W-1:0]        rd_idx_q;
	logic                    rd_vld_q;
	logic [ENTRY_W-1:0]      rdata_q;
	logic [ENTRY_W-1:0]      vtx_q;
	logic                    hit_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic                    out_valid_q;
	logic [OUT_IDX_W-1:0]    vertex_index_q;
	logic                    is_new_q;
	logic                    table_full_q;

	logic [CNT_W-1:0]        rd_ptr_dec;
	logic [IDX_W-1:0]        rd_addr;
	logic                    more;
	logic                    room;
	logic                    match;
	logic [2:0]              axis_ok;

	assign more       = (rd_ptr_q != '0);
	assign rd_ptr_dec = rd_ptr_q - CNT_W'(1);
	assign rd_addr    = rd_ptr_dec[IDX_W-1:0];
	assign room       = (count_q < CNT_W'(TABLE_DEPTH));

	// per-axis |entry - vertex| < tolerance, difference taken in 33 bits
	always_comb begin
		logic signed [COORD_W:0] a;
		logic signed [COORD_W:0] b;
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        mag;
		for (int k = 0; k < 3; k++) begin
			a   = {rdata_q[k*COORD_W + COORD_W-1], rdata_q[k*COORD_W +: COORD_W]};
			b   = {vtx_q[k*COORD_W + COORD_W-1], vtx_q[k*COORD_W +: COORD_W]};
			d   = a - b;
			mag = d[COORD_W] ? (COORD_W+1)'(-d) : d;
			axis_ok[k] = (mag < (COORD_W+1)'(tol_q));
		end
	end

	assign match = &axis_ok;

	assign sts.more     = more;
	assign sts.rd_vld   = rd_vld_q;
	assign sts.hit      = rd_vld_q && match;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rd_vld_q    <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.step && more;
			if (cmd.start) begin
				hit_q    <= 1'b0;
				rd_ptr_q <= new_mesh ? '0 : count_q;
				if (new_mesh) begin
					count_q <= '0;
				end
			end else if (cmd.step) begin
				if (more) begin
					rd_ptr_q <= rd_ptr_dec;
				end
				if (rd_vld_q && match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit && !hit_q && room) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: vertex, read tracking, result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vtx_q <= {z_coord, y_coord, x_coord};
		end
		if (cmd.step && more) begin
			rd_idx_q <= rd_addr;
		end
		if (cmd.step && rd_vld_q && match) begin
			hit_idx_q <= rd_idx_q;
		end
		if (cmd.commit) begin
			priority if (hit_q) begin
				vertex_index_q <= OUT_IDX_W'(hit_idx_q);
				is_new_q       <= 1'b0;
				table_full_q   <= 1'b0;
			end else if (room) begin
				vertex_index_q <= OUT_IDX_W'(count_q);
				is_new_q       <= 1'b1;
				table_full_q   <= 1'b0;
			end else begin
				vertex_index_q <= '0;
				is_new_q       <= 1'b0;
				table_full_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q && room) begin
			mem[count_q[IDX_W-1:0]] <= vtx_q;
		end
		if (cmd.step && more) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign is_new       = is_new_q;
	assign table_full   = table_full_q;

endmodule

>>> src/vertex_dedup_table.sv
// Vertex de-duplication table. Each request carries one vertex (signed Q16.16
// x, y, z) and returns one result: the index of the newest stored vertex whose
// three coordinates each lie strictly within match_tolerance (reset value 1,
// that is 2^-16) of it, or else the index at which the vertex was appended
// (is_new), or table_full with index 0 once all 256 entries are used. A set
// new_mesh empties the table before the vertex is looked up. The search reads
// the single-port table memory one entry per cycle, newest first, and stops at
// the first hit or once all stored entries have been compared. The result waits
// in an output register; a further request is taken once that result has been
// written there.
module vertex_dedup_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vdt_pkg::TOL_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [vdt_pkg::COORD_W-1:0] x_coord,
	input  logic signed [vdt_pkg::COORD_W-1:0] y_coord,
	input  logic signed [vdt_pkg::COORD_W-1:0] z_coord,
	input  logic                               new_mesh,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [vdt_pkg::OUT_IDX_W-1:0]      vertex_index,
	output logic                               is_new,
	output logic                               table_full
);
	import vdt_pkg::*;

	vdt_cmd_t cmd;
	vdt_sts_t sts;

	vdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vdt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.new_mesh     (new_mesh),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.is_new       (is_new),
		.table_full   (table_full)
	);

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.step, cmd.commit}))
		else $error("more than one command at once");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result written over one not yet taken");

	a_hit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> in_stall)
		else $error("search hit while open for a request");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!is_new && vertex_index == '0))
		else $error("table_full result with index or is_new set");
`endif

endmodule

>>> verif/tb_vertex_dedup_table.sv
`timescale 1ns / 1ps

module tb_vertex_dedup_table;

	import vdt_pkg::*;

	localparam logic [TOL_W-1:0]   TOL_MAX        = {TOL_W{1'b1}};
	localparam logic [COORD_W-1:0] C_MIN          = 32'h8000_0000;
	localparam logic [COORD_W-1:0] C_MAX          = 32'h7fff_ffff;
	localparam int                 HOLD_AT        = 680;
	localparam int                 HOLD_CYCLES    = 400;
	localparam int                 WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               new_mesh;
	} vertex_req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		logic                 is_new;
		logic                 full;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic signed [COORD_W-1:0] z_coord = '0;
	logic new_mesh = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_IDX_W-1:0] vertex_index;
	logic is_new;
	logic table_full;

	vertex_req_t vtx_queue [$];
	vertex_req_t gen_recent [$];
	lookup_t     due_lookups [$];
	vertex_req_t offered;
	lookup_t     seen_lookup;
	lookup_t     due_lookup;

	// predictor state
	vertex_req_t      welded [TABLE_DEPTH];
	int               welded_cnt = 0;
	logic [TOL_W-1:0] weld_tol = TOL_RESET;

	int send_idle_pct = 32;
	int recv_idle_pct = 87;
	int lookups_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;
	int errors = 0;

	vertex_dedup_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.new_mesh    (new_mesh),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vertex_index(vertex_index),
		.is_new      (is_new),
		.table_full  (table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit axis_near(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		longint d;
		// 33-bit exact difference, no wrap
		d = longint'($signed(a)) - longint'($signed(b));
		if (d < 0)
			d = -d;
		return d < longint'(weld_tol);
	endfunction

	function automatic lookup_t weld_vertex(vertex_req_t v);
		lookup_t r;
		int hit;
		hit = -1;
		if (v.new_mesh)
			welded_cnt = 0;
		// newest first, stop at the first close entry
		for (int i = welded_cnt - 1; i >= 0 && hit < 0; i--)
			if (axis_near(welded[i].x, v.x) && axis_near(welded[i].y, v.y) &&
			    axis_near(welded[i].z, v.z))
				hit = i;
		if (hit >= 0) begin
			r.index  = OUT_IDX_W'(hit);
			r.is_new = 1'b0;
			r.full   = 1'b0;
		end else if (welded_cnt < TABLE_DEPTH) begin
			welded[welded_cnt] = v;
			r.index  = OUT_IDX_W'(welded_cnt);
			r.is_new = 1'b1;
			r.full   = 1'b0;
			welded_cnt++;
		end else begin
			r.index  = '0;
			r.is_new = 1'b0;
			r.full   = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] fresh_coord();
		logic [COORD_W-1:0] corners [6] = '{C_MIN, C_MAX, 32'h0, 32'hffff_ffff, 32'h1,
			32'h8000_0001};
		if ($urandom_range(3) == 0)
			return corners[$urandom_range(5)];
		return $urandom();
	endfunction

	// offset a coordinate by zero, by the tolerance or one either side of it, or by a random amount up to it
	function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c);
		longint span;
		longint v;
		case ($urandom_range(4))
			0: span = 0;
			1: span = longint'(weld_tol) - 1;
			2: span = longint'(weld_tol);
			3: span = longint'(weld_tol) + 1;
			default: span = longint'($urandom_range(weld_tol));
		endcase
		if (span < 0)
			span = 0;
		v = longint'($signed(c)) + ($urandom_range(1) ? span : -span);
		if (v > longint'($signed(C_MAX)))
			v = longint'($signed(C_MAX));
		if (v < longint'($signed(C_MIN)))
			v = longint'($signed(C_MIN));
		return v[COORD_W-1:0];
	endfunction

	task automatic push_vtx(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [COORD_W-1:0] z, logic nm);
		vertex_req_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.new_mesh = nm;
		vtx_queue = {vtx_queue, v};
	endtask

	task automatic queue_random(int n, int mesh_odds, bit clear_first);
		vertex_req_t v;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (gen_recent.size() == 0 || pick < 20) begin
				v.x = fresh_coord();
				v.y = fresh_coord();
				v.z = fresh_coord();
			end else begin
				v = gen_recent[$urandom_range(gen_recent.size() - 1)];
				if (pick >= 35) begin
					v.x = nudge(v.x);
					v.y = nudge(v.y);
					v.z = nudge(v.z);
				end
			end
			v.new_mesh = (k == 0 && clear_first) ||
				(mesh_odds > 0 && $urandom_range(mesh_odds - 1) == 0);
			if (v.new_mesh)
				gen_recent.delete();
			gen_recent = {gen_recent, v};
			vtx_queue = {vtx_queue, v};
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (vtx_queue.size() != 0 || in_valid || due_lookups.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_tol(logic [TOL_W-1:0] tol);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= tol;
		@(posedge clk);
		cfg_we   <= 1'b0;
		weld_tol = tol;
	endtask

	task automatic run_phase(logic [TOL_W-1:0] tol, int n, int mesh_odds, bit clear_first);
		write_tol(tol);
		queue_random(n, mesh_odds, clear_first);
		drain();
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				due_lookups = {due_lookups, weld_vertex(offered)};
			if (!in_valid || !in_stall) begin
				if (vtx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = vtx_queue.pop_front();
					in_valid <= 1'b1;
					x_coord  <= offered.x;
					y_coord  <= offered.y;
					z_coord  <= offered.z;
					new_mesh <= offered.new_mesh;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_lookup = {vertex_index, is_new, table_full};
				lookups_seen++;
				if (due_lookups.size() == 0) begin
					$display("%0t: unexpected result: index %0d new %0b full %0b", $realtime,
						vertex_index, is_new, table_full);
					errors++;
				end else begin
					due_lookup = due_lookups.pop_front();
					if (seen_lookup !== due_lookup) begin
						$display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							$realtime, due_lookup.index, due_lookup.is_new, due_lookup.full,
							seen_lookup.index, seen_lookup.is_new, seen_lookup.full);
						errors++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_left == 0 && !hold_done && lookups_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[vertex_dedup_table] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset tolerance: only exact coordinates match
		push_vtx(32'h0, 32'h0, 32'h0, 1'b1);
		push_vtx(32'h0, 32'h0, 32'h0, 1'b0);
		push_vtx(32'h1, 32'h0, 32'h0, 1'b0);
		push_vtx(32'h0, 32'h0, 32'hffff_ffff, 1'b0);
		push_vtx(C_MAX, C_MAX, C_MAX, 1'b0);
		push_vtx(C_MIN, C_MIN, C_MIN, 1'b0);
		push_vtx(C_MAX, C_MAX, C_MAX, 1'b0);
		push_vtx(C_MIN, C_MIN, C_MIN, 1'b0);
		push_vtx(32'h0, 32'h0, 32'h0, 1'b0);
		push_vtx(C_MAX, C_MIN, C_MAX, 1'b1);
		push_vtx(C_MIN, C_MAX, C_MIN, 1'b0);
		push_vtx(C_MAX, C_MIN, C_MAX, 1'b0);
		push_vtx(32'h0, 32'h0, 32'h0, 1'b0);
		drain();

		// widest tolerance: differences span the full 33-bit range
		write_tol(TOL_MAX);
		push_vtx(32'h0, 32'h0, 32'h0, 1'b1);
		push_vtx(32'h7fff_fffe, 32'h8000_0002, 32'h0, 1'b0);
		push_vtx(C_MAX, 32'h0, 32'h0, 1'b0);
		push_vtx(C_MIN, 32'h0, 32'h0, 1'b0);
		push_vtx(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		push_vtx(C_MIN, C_MAX, C_MIN, 1'b0);
		drain();

		// zero tolerance fills the table and runs past full
		run_phase('0, 262, 0, 1'b1);
		// full table: repeats still hit, fresh vertices are dropped
		run_phase(TOL_W'(1), 24, 0, 1'b0);
		run_phase(TOL_W'(32'h1_0000), 110, 40, 1'b1);

		send_idle_pct = 87;
		recv_idle_pct = 32;
		run_phase(TOL_W'(32'h100), 110, 40, 1'b1);
		run_phase(TOL_W'($urandom_range(TOL_MAX)), 110, 40, 1'b1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(TOL_MAX, 110, 40, 1'b1);
		run_phase(TOL_W'(1), 110, 40, 1'b1);

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[vertex_dedup_table] OK");
		else
			$display("[vertex_dedup_table] ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/vdt_pkg.sv
src/vdt_ctrl.sv
src/vdt_dpath.sv
src/vertex_dedup_table.sv
verif/tb_vertex_dedup_table.sv
